FILE: src/tcw_pkg.sv
// ---------------------------------------------------------------------------
// Text console writer package
// Geometry constants, field widths, action codes, controller states and the
// command/status structs that join controller and datapath.
// ---------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CNT_W   = $clog2(CELLS + 1);   // holds CELLS itself

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int IDX_W   = 11;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = ATTR_W + CHAR_W;

   localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
   localparam logic [CHAR_W-1:0] LINE_FEED  = 8'h0A;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_SET   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_CLEAR  = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_READ   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;       // take the request beat, update cursor, single write/read
      logic fill;         // write a space cell at the sweep counter
      logic fill_init;    // fill uses the reset attribute, not the register
      logic scroll;       // one step of the scroll walk
      logic emit;         // load the result registers, strobe next cycle
      logic emit_read;    // result carries the cell read
      logic emit_scroll;  // result flags a scroll
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_scroll;  // pending write/line feed leaves the bottom row
      logic fill_last;    // sweep counter on the last cell
      logic scroll_last;  // scroll walk writing its last cell
   } stat_type;

endpackage

FILE: src/tcw_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// Text console controller
// One-hot sequencer: reset clear pass, action dispatch, clear and scroll walks.
// ---------------------------------------------------------------------------
module tcw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_action,
   input  tcw_pkg::stat_type stat,
   output tcw_pkg::cmd_type  cmd,
   output logic              busy
);
   import tcw_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.fill      = 1'b1;
            cmd.fill_init = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               case (req_action)
                  ACT_WRITE: state_in = stat.need_scroll ? ST_SCROLL : ST_DONE;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  ACT_SET:   state_in = ST_DONE;
                  ACT_READ:  state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.fill = 1'b1;
            if (stat.fill_last) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            cmd.scroll = 1'b1;
            if (stat.scroll_last) begin
               cmd.emit        = 1'b1;
               cmd.emit_scroll = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.emit      = 1'b1;
            cmd.emit_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start work");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("read did not finish in one cycle");

endmodule

FILE: src/tcw_dp.sv
// ---------------------------------------------------------------------------
// Text console datapath
// Cursor, attribute register, sweep counter, text store and result registers.
// ---------------------------------------------------------------------------
module tcw_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::cmd_type              cmd,
   output tcw_pkg::stat_type             stat,
   input  logic [1:0]                    req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]     req_target_col,
   input  logic [tcw_pkg::ROW_W-1:0]     req_target_row,
   input  logic [tcw_pkg::IDX_W-1:0]     req_read_index,
   input  logic                          attr_we,
   input  logic [tcw_pkg::ATTR_W-1:0]    attr_wdata,
   output logic [tcw_pkg::ATTR_W-1:0]    attr_value,
   output logic                          rsp_valid,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col_out,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row_out,
   output logic [tcw_pkg::IDX_W-1:0]     rsp_cursor_index,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic                          rsp_scrolled
);
   import tcw_pkg::*;

   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [ATTR_W-1:0] attr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rd_ok_ff;

   logic              rsp_valid_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic              rsp_scrolled_ff;

   int                cur_lin;
   logic              last_col, last_row, is_lf, wrap, rd_ok;
   logic [CNT_W:0]    scr_rd_ptr;
   logic [CNT_W-1:0]  scr_wr_ptr;
   logic [CELL_W-1:0] space_cell;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   always_comb begin
      cur_lin    = int'(cursor_row_ff) * COLUMNS + int'(cursor_col_ff);
      last_col   = (int'(cursor_col_ff) == COLUMNS - 1);
      last_row   = (int'(cursor_row_ff) == ROWS - 1);
      is_lf      = (req_char_code == LINE_FEED);
      wrap       = is_lf || last_col;
      rd_ok      = (int'(req_read_index) < CELLS);
      scr_rd_ptr = {1'b0, cnt_ff} + (CNT_W+1)'(COLUMNS);
      scr_wr_ptr = cnt_ff - 1'b1;
      space_cell = {attr_ff, SPACE_CODE};

      stat.need_scroll = (req_action == ACT_WRITE) && wrap && last_row;
      stat.fill_last   = (cnt_ff == CNT_W'(CELLS - 1));
      stat.scroll_last = (cnt_ff == CNT_W'(CELLS));
   end

   // cursor update on an accepted beat
   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (cmd.accept) begin
         case (req_action)
            ACT_WRITE: begin
               if (wrap) begin
                  cursor_col_in = '0;
                  if (!last_row) begin
                     cursor_row_in = cursor_row_ff + 1'b1;
                  end
               end else begin
                  cursor_col_in = cursor_col_ff + 1'b1;
               end
            end
            ACT_CLEAR: begin
               cursor_col_in = '0;
               cursor_row_in = '0;
            end
            ACT_SET: begin
               cursor_col_in = (int'(req_target_col) < COLUMNS) ? req_target_col
                                                               : COL_W'(COLUMNS - 1);
               cursor_row_in = (int'(req_target_row) < ROWS) ? req_target_row
                                                            : ROW_W'(ROWS - 1);
            end
            ACT_READ: begin
            end
            default: begin
            end
         endcase
      end
   end

   // store port steering
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;
      if (cmd.accept) begin
         if ((req_action == ACT_WRITE) && !is_lf) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(cur_lin);
            ram_wdata = {attr_ff, req_char_code};
         end
         if ((req_action == ACT_READ) && rd_ok) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(req_read_index);
         end
      end
      if (cmd.fill) begin
         // reset pass ignores register writes made while it runs
         ram_we    = 1'b1;
         ram_waddr = cnt_ff[ADDR_W-1:0];
         ram_wdata = cmd.fill_init ? {RESET_ATTR, SPACE_CODE} : space_cell;
      end
      if (cmd.scroll) begin
         // read one row ahead, write the cell read last cycle one row up
         if (cnt_ff != '0) begin
            ram_we    = 1'b1;
            ram_waddr = scr_wr_ptr[ADDR_W-1:0];
            ram_wdata = (int'(cnt_ff) <= CELLS - COLUMNS) ? ram_rdata : space_cell;
         end
         if (int'(scr_rd_ptr) < CELLS) begin
            ram_re    = 1'b1;
            ram_raddr = scr_rd_ptr[ADDR_W-1:0];
         end
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         attr_ff       <= RESET_ATTR;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         if (attr_we) begin
            attr_ff <= attr_wdata;
         end
         if (cmd.accept) begin
            cnt_ff <= '0;
         end else if (cmd.fill || cmd.scroll) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ok_ff <= rd_ok;
      end
      if (cmd.emit) begin
         rsp_col_ff      <= cursor_col_ff;
         rsp_row_ff      <= cursor_row_ff;
         rsp_idx_ff      <= IDX_W'(cur_lin);
         rsp_cell_ff     <= (cmd.emit_read && rd_ok_ff) ? ram_rdata : '0;
         rsp_scrolled_ff <= cmd.emit_scroll;
      end
   end

   assign attr_value         = attr_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_index   = rsp_idx_ff;
   assign rsp_cell_value     = rsp_cell_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cursor_col_ff) < COLUMNS) && (int'(cursor_row_ff) < ROWS))
      else $error("cursor outside the screen");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |->
         ((rsp_col_ff == '0) && (int'(rsp_row_ff) == ROWS - 1)))
      else $error("scroll result not at start of bottom row");

endmodule

FILE: src/text_console_writer.sv
// ---------------------------------------------------------------------------
// Text console writer
// 80x25 text screen of 16-bit cells (attribute over character) with a cursor.
// ---------------------------------------------------------------------------
// One beat is taken when start is high and busy is low; each beat gives one
// result, strobed on rsp_valid for a single cycle with no way to hold it off.
// Set cursor, read cell and a write or line feed that stays on screen go
// through the done or read state before the strobe. Clear screen and a write
// or line feed that leaves the bottom row walk the whole store: it has one
// write and one read port, so the clear and scroll walks go through it one
// cell per cycle. After reset busy stays high while the store is filled with
// spaces on attribute 0x0F; configuration writes are taken throughout.
// Register cell_attribute answers at every address of the 2-bit window and
// sets the attribute of written and cleared cells.
// ---------------------------------------------------------------------------
module text_console_writer (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]     req_target_col,
   input  logic [tcw_pkg::ROW_W-1:0]     req_target_row,
   input  logic [tcw_pkg::IDX_W-1:0]     req_read_index,
   // result
   output logic                          rsp_valid,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col_out,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row_out,
   output logic [tcw_pkg::IDX_W-1:0]     rsp_cursor_index,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic                          rsp_scrolled,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [1:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import tcw_pkg::*;

   cmd_type           cmd;
   stat_type          stat;
   logic              attr_we;
   logic [ATTR_W-1:0] attr_value;

   // single register: every address in the 2-bit window decodes to it
   assign csr_pready = 1'b1;
   assign attr_we    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == csr_paddr);
   assign csr_prdata = {{(32-ATTR_W){1'b0}}, attr_value};

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   tcw_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_target_col     (req_target_col),
      .req_target_row     (req_target_row),
      .req_read_index     (req_read_index),
      .attr_we            (attr_we),
      .attr_wdata         (csr_pwdata[ATTR_W-1:0]),
      .attr_value         (attr_value),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_index   (rsp_cursor_index),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_scrolled       (rsp_scrolled)
   );

endmodule

FILE: tb/text_console_writer_tb.sv
// ---------------------------------------------------------------------------
// Text console writer testbench
// Sends console actions over the start/busy port and keeps its own copy of
// the screen, cursor and attribute. Every result beat is checked field by
// field against the hand-worked status of the opening table or, for random
// traffic, against that copy. The table runs first; random traffic follows in
// phases, each with its own attribute, the sender gap rate changing every two.
// ---------------------------------------------------------------------------
module text_console_writer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam logic [1:0] ATTR_ADDR       = 2'd0;
   localparam int         PHASES          = 6;
   localparam int         ITEMS_PER_PHASE = 275;
   // A scroll walk runs with no beat at all. Allow several of those before the
   // run is declared stuck.
   localparam int         STALL_LIMIT     = 10000;

   typedef struct packed {
      action_type        act;
      logic [CHAR_W-1:0] ch;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [IDX_W-1:0]  idx;
   } console_cmd_type;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [IDX_W-1:0]  idx;
      logic [CELL_W-1:0] cell_val;
      logic              scrolled;
   } console_status_type;

   typedef struct packed {
      console_cmd_type    cmd;
      logic               known;    // status below was worked out by hand
      console_status_type status;
   } directed_row_type;

   // Hand-checked opening sequence, from reset with attribute 0x0F.
   //   command: action, char, col, row, index     status: col, row, index, cell, scrolled
   localparam directed_row_type DIRECTED [25] = '{
      '{'{ACT_READ,  'h00,       0,   0,    0}, 1, '{ 0,  0,    0, 'h0F20, 0}},
      '{'{ACT_READ,  'h00,       0,   0, 2047}, 1, '{ 0,  0,    0,      0, 0}},
      '{'{ACT_READ,  'h00,       0,   0, 2000}, 1, '{ 0,  0,    0,      0, 0}},
      '{'{ACT_READ,  'h00,       0,   0, 1999}, 1, '{ 0,  0,    0, 'h0F20, 0}},
      '{'{ACT_WRITE, 'h41,       0,   0,    0}, 1, '{ 1,  0,    1,      0, 0}},
      '{'{ACT_READ,  'h00,       0,   0,    0}, 1, '{ 1,  0,    1, 'h0F41, 0}},
      '{'{ACT_WRITE, 'h00,       0,   0,    0}, 1, '{ 2,  0,    2,      0, 0}},
      '{'{ACT_WRITE, 'hFF,       0,   0,    0}, 1, '{ 3,  0,    3,      0, 0}},
      '{'{ACT_READ,  'h00,       0,   0,    2}, 1, '{ 3,  0,    3, 'h0FFF, 0}},
      '{'{ACT_WRITE, LINE_FEED,  0,   0,    0}, 1, '{ 0,  1,   80,      0, 0}},
      '{'{ACT_SET,   'h00,     127,  31,    0}, 1, '{79, 24, 1999,      0, 0}},
      '{'{ACT_WRITE, 'h5A,       0,   0,    0}, 1, '{ 0, 24, 1920,      0, 1}},
      '{'{ACT_READ,  'h00,       0,   0, 1999}, 1, '{ 0, 24, 1920, 'h0F20, 0}},
      '{'{ACT_READ,  'h00,       0,   0, 1919}, 1, '{ 0, 24, 1920, 'h0F5A, 0}},
      '{'{ACT_READ,  'h00,       0,   0,    0}, 1, '{ 0, 24, 1920, 'h0F20, 0}},
      '{'{ACT_WRITE, LINE_FEED,  0,   0,    0}, 1, '{ 0, 24, 1920,      0, 1}},
      '{'{ACT_READ,  'h00,       0,   0, 1839}, 1, '{ 0, 24, 1920, 'h0F5A, 0}},
      '{'{ACT_SET,   'h00,       0,   0,    0}, 1, '{ 0,  0,    0,      0, 0}},
      '{'{ACT_SET,   'h00,      79,   0,    0}, 1, '{79,  0,   79,      0, 0}},
      '{'{ACT_WRITE, 'h7E,       0,   0,    0}, 1, '{ 0,  1,   80,      0, 0}},
      '{'{ACT_READ,  'h00,       0,   0,   79}, 1, '{ 0,  1,   80, 'h0F7E, 0}},
      '{'{ACT_SET,   'h00,      80,  25,    0}, 1, '{79, 24, 1999,      0, 0}},
      '{'{ACT_CLEAR, 'h00,       0,   0,    0}, 1, '{ 0,  0,    0,      0, 0}},
      '{'{ACT_READ,  'h00,       0,   0, 1839}, 1, '{ 0,  0,    0, 'h0F20, 0}},
      '{'{ACT_SET,   'hA5,       0,  24, 1234}, 1, '{ 0, 24, 1920,      0, 0}}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_action = ACT_WRITE;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic [COL_W-1:0]  req_target_col = '0;
   logic [ROW_W-1:0]  req_target_row = '0;
   logic [IDX_W-1:0]  req_read_index = '0;
   logic              rsp_valid;
   logic [COL_W-1:0]  rsp_cursor_col_out;
   logic [ROW_W-1:0]  rsp_cursor_row_out;
   logic [IDX_W-1:0]  rsp_cursor_index;
   logic [CELL_W-1:0] rsp_cell_value;
   logic              rsp_scrolled;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [1:0]        csr_paddr = ATTR_ADDR;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // Shadow of the console: screen, cursor and current attribute.
   logic [CELL_W-1:0] screen_shadow [CELLS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [ATTR_W-1:0] attr_shadow;

   console_status_type awaited_status [$];   // one entry per accepted beat
   int unsigned        error_count  = 0;
   int unsigned        quiet_cycles = 0;
   int unsigned        gap_pct      = 7;     // chance in 100 of an idle cycle

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_writer u_top (.*);

   // -------------------------------------------------------------------------
   // Console prediction
   // -------------------------------------------------------------------------
   function automatic void reset_shadow();
      foreach (screen_shadow[i]) screen_shadow[i] = {RESET_ATTR, SPACE_CODE};
      cur_col     = 0;
      cur_row     = 0;
      attr_shadow = RESET_ATTR;
   endfunction

   // Go to the start of the next line; off the bottom the screen moves up a
   // row and the freed bottom row is blanked with the current attribute.
   function automatic logic new_line();
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS) return 1'b0;
      for (int i = COLUMNS; i < CELLS; i++) screen_shadow[i-COLUMNS] = screen_shadow[i];
      for (int i = CELLS - COLUMNS; i < CELLS; i++)
         screen_shadow[i] = {attr_shadow, SPACE_CODE};
      cur_row = ROWS - 1;
      return 1'b1;
   endfunction

   function automatic console_status_type predict_console(input console_cmd_type c);
      console_status_type s;
      s = '0;
      case (c.act)
         ACT_WRITE: begin
            if (c.ch == LINE_FEED) begin
               s.scrolled = new_line();
            end else begin
               screen_shadow[cur_row*COLUMNS + cur_col] = {attr_shadow, c.ch};
               cur_col++;
               if (cur_col >= COLUMNS) s.scrolled = new_line();
            end
         end
         ACT_CLEAR: begin
            foreach (screen_shadow[i]) screen_shadow[i] = {attr_shadow, SPACE_CODE};
            cur_col = 0;
            cur_row = 0;
         end
         ACT_SET: begin
            // out-of-range targets stick at the last column / row
            cur_col = (c.col < COLUMNS) ? c.col : COLUMNS - 1;
            cur_row = (c.row < ROWS) ? c.row : ROWS - 1;
         end
         default: begin
            if (c.idx < CELLS) s.cell_val = screen_shadow[c.idx];
         end
      endcase
      s.col = COL_W'(cur_col);
      s.row = ROW_W'(cur_row);
      s.idx = IDX_W'(cur_row*COLUMNS + cur_col);
      return s;
   endfunction

   // -------------------------------------------------------------------------
   // Random traffic. Mostly character writes with the odd line feed, so text
   // runs across lines and off the bottom; half the reads look just behind the
   // cursor, where text has landed. Unused fields carry random bits.
   // -------------------------------------------------------------------------
   function automatic console_cmd_type random_cmd();
      console_cmd_type c;
      int unsigned     pick;
      int unsigned     here;
      c.act = action_type'($urandom_range(3));
      c.ch  = CHAR_W'($urandom);
      c.col = COL_W'($urandom);
      c.row = ROW_W'($urandom);
      c.idx = IDX_W'($urandom);
      pick  = $urandom_range(99);
      here  = cur_row*COLUMNS + cur_col;
      if (pick < 2) begin
         c.act = ACT_CLEAR;
      end else if (pick < 14) begin
         c.act = ACT_SET;
         case ($urandom_range(3))
            0: ;                                   // anywhere, saturation too
            1: begin                               // near the bottom
               c.row = ROW_W'(ROWS - 1 - $urandom_range(1));
               c.col = COL_W'($urandom_range(COLUMNS - 1));
            end
            2: begin                               // near the right edge
               c.row = ROW_W'($urandom_range(ROWS - 1));
               c.col = COL_W'(COLUMNS - 1 - $urandom_range(2));
            end
            default: begin
               c.row = ROW_W'($urandom_range(ROWS - 1));
               c.col = COL_W'($urandom_range(COLUMNS - 1));
            end
         endcase
      end else if (pick < 34) begin
         c.act = ACT_READ;
         case ($urandom_range(3))
            0, 1: c.idx = IDX_W'((here + CELLS - 1 - $urandom_range(COLUMNS)) % CELLS);
            2: c.idx = IDX_W'($urandom_range(CELLS - 1));
            default: ;                             // full range, past the end too
         endcase
      end else begin
         c.act = ACT_WRITE;
         if ($urandom_range(99) < 6) c.ch = LINE_FEED;
      end
      return c;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // start is only dropped for a gap or a drain, so back-to-back beats keep it high.
   task automatic send_beat(input console_cmd_type c, input logic known,
                            input console_status_type typed);
      console_status_type predicted;
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= c.act;
      req_char_code  <= c.ch;
      req_target_col <= c.col;
      req_target_row <= c.row;
      req_read_index <= c.idx;
      do @(posedge clock); while (busy);
      predicted = predict_console(c);
      awaited_status.push_back(known ? typed : predicted);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the edge that ends the access completes it.
   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ATTR_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Upper data bits are junk: only the low byte lands in the register.
   task automatic write_attr(input logic [ATTR_W-1:0] a);
      logic [31:0] unused;
      csr_access(1'b1, {24'($urandom), a}, unused);
      attr_shadow = a;
   endtask

   task automatic check_attr();
      logic [31:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd[ATTR_W-1:0] !== attr_shadow) begin
         error_count++;
         $display("%0t: cell_attribute read expected 0x%0h got 0x%0h",
                  $time, attr_shadow, rd[ATTR_W-1:0]);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: one beat per strobe, compared with the oldest expectation.
   // -------------------------------------------------------------------------
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      console_status_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid) begin
            if (awaited_status.size() == 0) begin
               error_count++;
               $display("%0t: result beat with nothing expected, cursor %0d,%0d",
                        $time, rsp_cursor_col_out, rsp_cursor_row_out);
            end else begin
               want = awaited_status.pop_front();
               check_field("cursor_col_out", want.col, rsp_cursor_col_out);
               check_field("cursor_row_out", want.row, rsp_cursor_row_out);
               check_field("cursor_index", want.idx, rsp_cursor_index);
               check_field("cell_value", want.cell_val, rsp_cell_value);
               check_field("scrolled", want.scrolled, rsp_scrolled);
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, awaited_status.size());
            $display("[text_console_writer] ERROR");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Run
   // -------------------------------------------------------------------------
   initial begin
      logic [ATTR_W-1:0] next_attr;
      reset_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Register is taken during the clearing pass; check its reset value
      // before writing it.
      check_attr();
      write_attr(RESET_ATTR);
      for (int i = 0; i < $size(DIRECTED); i++)
         send_beat(DIRECTED[i].cmd, DIRECTED[i].known, DIRECTED[i].status);

      // Random phases: attribute extremes, 0x80 and random values, sender gaps of
      // 7 in 100 first, then 46 in 100, then none.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0:       next_attr = '0;
            1:       next_attr = '1;
            3:       next_attr = 8'h80;
            default: next_attr = ATTR_W'($urandom);
         endcase
         write_attr(next_attr);
         check_attr();
         gap_pct = (p < 2) ? 7 : (p < 4) ? 46 : 0;
         repeat (ITEMS_PER_PHASE) send_beat(random_cmd(), 1'b0, '0);
      end

      drain();
      repeat (10) @(posedge clock);   // catch any stray strobe
      if (error_count == 0) begin
         $display("[text_console_writer] OK");
      end else begin
         $display("[text_console_writer] ERROR");
      end
      $finish;
   end

endmodule
